[src/desktop_grid_navigator_core_assert.svh]
// Assertion macros shared by the navigator checkers.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef DESKTOP_GRID_NAVIGATOR_CORE_ASSERT_SVH
`define DESKTOP_GRID_NAVIGATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("navigator check failed");

// The consequent must hold in the cycle after the antecedent.
`define DGN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("navigator check failed");

`endif

[src/dgn_pkg.sv]
package dgn_pkg;

  // Grid and desktop limits.
  localparam int unsigned MAX_SIDE     = 16;
  localparam int unsigned MAX_DESKTOPS = 256;

  // Restoring divide of an 8-bit index takes one step per bit.
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Command codes.
  localparam logic [2:0] OP_NORTH  = 3'd0;
  localparam logic [2:0] OP_SOUTH  = 3'd1;
  localparam logic [2:0] OP_EAST   = 3'd2;
  localparam logic [2:0] OP_WEST   = 3'd3;
  localparam logic [2:0] OP_SELECT = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Register indexes (word address).
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_ROWS      = 3'd0;
  localparam logic [2:0] REG_COLUMNS   = 3'd1;
  localparam logic [2:0] REG_ROW_MAJOR = 3'd2;
  localparam logic [2:0] REG_CORNER    = 3'd3;
  localparam logic [2:0] REG_COUNT     = 3'd4;

  // Raw configuration register contents.
  typedef struct packed {
    logic [4:0] rows;
    logic [4:0] cols;
    logic       row_major;
    logic [1:0] corner;
    logic [8:0] count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic place;
    logic walk;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_walk;
    logic walk_end;
  } dp_stat_t;

endpackage

[src/dgn_regs.sv]
module dgn_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         reg_idx,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output dgn_pkg::cfg_t      cfg
);
  import dgn_pkg::*;

  logic [4:0] rows_r;
  logic [4:0] cols_r;
  logic       row_major_r;
  logic [1:0] corner_r;
  logic [8:0] count_r;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= 5'd1;
      cols_r      <= 5'd1;
      row_major_r <= 1'b1;
      corner_r    <= 2'd0;
      count_r     <= 9'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROWS:      rows_r      <= pwdata[4:0];
        REG_COLUMNS:   cols_r      <= pwdata[4:0];
        REG_ROW_MAJOR: row_major_r <= pwdata[0];
        REG_CORNER:    corner_r    <= pwdata[1:0];
        REG_COUNT:     count_r     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_ROWS:      prdata = {27'd0, rows_r};
      REG_COLUMNS:   prdata = {27'd0, cols_r};
      REG_ROW_MAJOR: prdata = {31'd0, row_major_r};
      REG_CORNER:    prdata = {30'd0, corner_r};
      REG_COUNT:     prdata = {23'd0, count_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.rows      = rows_r;
  assign cfg.cols      = cols_r;
  assign cfg.row_major = row_major_r;
  assign cfg.corner    = corner_r;
  assign cfg.count     = count_r;

endmodule

[src/dgn_ctrl.sv]
module dgn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dgn_pkg::dp_stat_t   stat,
  output dgn_pkg::dp_cmd_t    cmd
);
  import dgn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_CELL = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Sequencer: accept, divide, place on grid, walk, hand off.
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        cmd.place = 1'b1;
        state_nxt = stat.start_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid: set on load, cleared when taken.
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/dgn_dp.sv]
module dgn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dgn_pkg::cfg_t      cfg,
  input  dgn_pkg::dp_cmd_t   cmd,
  output dgn_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_op,
  input  logic               in_wrap_enable,
  input  logic [7:0]         in_target_desktop,
  output logic [1:0]         out_status,
  output logic [7:0]         out_current_desktop_out,
  output logic [3:0]         out_current_row,
  output logic [3:0]         out_current_column
);
  import dgn_pkg::*;

  localparam logic [4:0] SIDE_MAX  = 5'(MAX_SIDE);
  localparam logic [8:0] COUNT_MAX = 9'(MAX_DESKTOPS);

  // Effective configuration after clamping.
  logic [4:0] rows_eff, cols_eff;
  logic [3:0] rows_m1, cols_m1;
  logic [8:0] count_eff, total;

  // Item and walk state.
  logic [7:0] cur_r;
  logic [2:0] op_r;
  logic       wrap_r;
  logic       sel_r;
  logic [7:0] idx_r;
  logic [7:0] quo_r;
  logic [3:0] rem_r;
  logic [3:0] wr_r, wc_r;
  logic [3:0] res_row_r, res_col_r;
  logic [8:0] steps_r;
  logic [1:0] status_r;

  // Result register.
  logic [1:0] o_status_r;
  logic [7:0] o_cur_r;
  logic [3:0] o_row_r, o_col_r;

  logic       sel_hit;
  logic [4:0] divisor, trial;
  logic       trial_ge;
  logic       on_grid;
  logic [3:0] r_raw, c_raw, r_vis, c_vis;
  logic [3:0] nr, nc, ru, cu;
  logic       edge_hit;
  logic [8:0] cand;
  logic       cand_hit, exhausted, edge_stop;

  always_comb begin
    if (cfg.rows == 5'd0)        rows_eff = 5'd1;
    else if (cfg.rows > SIDE_MAX) rows_eff = SIDE_MAX;
    else                          rows_eff = cfg.rows;
    if (cfg.cols == 5'd0)        cols_eff = 5'd1;
    else if (cfg.cols > SIDE_MAX) cols_eff = SIDE_MAX;
    else                          cols_eff = cfg.cols;
    count_eff = (cfg.count > COUNT_MAX) ? COUNT_MAX : cfg.count;
  end

  assign rows_m1 = 4'(rows_eff - 5'd1);
  assign cols_m1 = 4'(cols_eff - 5'd1);
  assign total   = 9'(rows_eff) * 9'(cols_eff);

  // A valid select divides the target, anything else the current index.
  assign sel_hit = (in_op == OP_SELECT) && ({1'b0, in_target_desktop} < count_eff);

  // One restoring divide step per cycle by the side along the fill order.
  assign divisor  = cfg.row_major ? cols_eff : rows_eff;
  assign trial    = {rem_r, quo_r[7]};
  assign trial_ge = (trial >= divisor);

  // Quotient and remainder to visual row and column.
  assign on_grid = ({1'b0, idx_r} < total);
  assign r_raw   = cfg.row_major ? quo_r[3:0] : rem_r;
  assign c_raw   = cfg.row_major ? rem_r : quo_r[3:0];
  assign r_vis   = cfg.corner[1] ? (rows_m1 - r_raw) : r_raw;
  assign c_vis   = cfg.corner[0] ? (cols_m1 - c_raw) : c_raw;

  // One cell move in the commanded direction.
  always_comb begin
    nr       = wr_r;
    nc       = wc_r;
    edge_hit = 1'b0;
    unique case (op_r)
      OP_NORTH: begin
        if (wr_r == 4'd0) begin
          edge_hit = 1'b1;
          nr       = rows_m1;
        end else begin
          nr = wr_r - 4'd1;
        end
      end
      OP_SOUTH: begin
        if (wr_r == rows_m1) begin
          edge_hit = 1'b1;
          nr       = 4'd0;
        end else begin
          nr = wr_r + 4'd1;
        end
      end
      OP_EAST: begin
        if (wc_r == cols_m1) begin
          edge_hit = 1'b1;
          nc       = 4'd0;
        end else begin
          nc = wc_r + 4'd1;
        end
      end
      default: begin
        if (wc_r == 4'd0) begin
          edge_hit = 1'b1;
          nc       = cols_m1;
        end else begin
          nc = wc_r - 4'd1;
        end
      end
    endcase
  end

  // Candidate cell back to its index, then check against the count.
  assign ru   = cfg.corner[1] ? (rows_m1 - nr) : nr;
  assign cu   = cfg.corner[0] ? (cols_m1 - nc) : nc;
  assign cand = cfg.row_major ? (9'(ru) * 9'(cols_eff) + 9'(cu))
                              : (9'(cu) * 9'(rows_eff) + 9'(ru));
  assign cand_hit  = (cand < count_eff);
  assign exhausted = (steps_r >= total);
  assign edge_stop = edge_hit && !wrap_r;

  assign stat.walk_end   = exhausted || edge_stop || cand_hit;
  assign stat.start_walk = (count_eff != 9'd0) && !op_r[2] && on_grid;

  // Current desktop is the only datapath state that resets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= 8'd0;
    end else if (cmd.place && sel_r) begin
      cur_r <= idx_r;
    end else if (cmd.walk && !exhausted && !edge_stop && cand_hit) begin
      cur_r <= cand[7:0];
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      wrap_r <= in_wrap_enable;
      sel_r  <= sel_hit;
      idx_r  <= sel_hit ? in_target_desktop : cur_r;
      quo_r  <= sel_hit ? in_target_desktop : cur_r;
      rem_r  <= 4'd0;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? 4'(trial - divisor) : trial[3:0];
      quo_r <= {quo_r[6:0], trial_ge};
    end
    if (cmd.place) begin
      wr_r      <= r_vis;
      wc_r      <= c_vis;
      res_row_r <= on_grid ? r_vis : 4'd0;
      res_col_r <= on_grid ? c_vis : 4'd0;
      steps_r   <= 9'd0;
      if (count_eff == 9'd0) begin
        status_r <= ST_EMPTY;
      end else if (sel_r) begin
        status_r <= ST_DONE;
      end else begin
        status_r <= ST_NONE;
      end
    end
    if (cmd.walk && !stat.walk_end) begin
      wr_r    <= nr;
      wc_r    <= nc;
      steps_r <= steps_r + 9'd1;
    end
    if (cmd.walk && !exhausted && !edge_stop && cand_hit) begin
      res_row_r <= nr;
      res_col_r <= nc;
      status_r  <= ST_DONE;
    end
    if (cmd.out_load) begin
      o_status_r <= status_r;
      o_cur_r    <= cur_r;
      o_row_r    <= res_row_r;
      o_col_r    <= res_col_r;
    end
  end

  assign out_status              = o_status_r;
  assign out_current_desktop_out = o_cur_r;
  assign out_current_row         = o_row_r;
  assign out_current_column      = o_col_r;

endmodule

[src/desktop_grid_navigator_core.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_op, in_wrap_enable, in_target_desktop
// out_      output     out_valid / out_stall  out_status, out_current_desktop_out,
//                                             out_current_row, out_current_column
// config    input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An item is accepted, its index placed on the grid by a bit-serial divide, and then, for
// a move, a walk over gap cells runs until a desktop is hit, an edge stops it without wrap,
// or rows*columns cells have been stepped; the result then goes to the output register.
// One item is in flight at a time; the next is taken once the result is in the
// output register, even while that result is stalled.
// Reset is synchronous and active low; it restores the register defaults and desktop 0.
module desktop_grid_navigator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic        in_wrap_enable,
  input  logic [7:0]  in_target_desktop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_current_desktop_out,
  output logic [3:0]  out_current_row,
  output logic [3:0]  out_current_column,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dgn_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dgn_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  // Configuration registers.
  dgn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_idx (paddr[ADDR_W-1:2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Sequencer.
  dgn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Divide, grid placement, walk and result register.
  dgn_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg),
    .cmd                     (cmd),
    .stat                    (stat),
    .in_op                   (in_op),
    .in_wrap_enable          (in_wrap_enable),
    .in_target_desktop       (in_target_desktop),
    .out_status              (out_status),
    .out_current_desktop_out (out_current_desktop_out),
    .out_current_row         (out_current_row),
    .out_current_column      (out_current_column)
  );

endmodule

[src/dgn_checker.sv]
`include "desktop_grid_navigator_core_assert.svh"

module dgn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_current_desktop_out,
  input logic [3:0] out_current_row,
  input logic [3:0] out_current_column
);
  import dgn_pkg::*;

  // A stalled result stays valid and unchanged.
  `DGN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_current_desktop_out) && $stable(out_current_row) && $stable(out_current_column))

  // Only one item is worked on at a time.
  `DGN_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

  // A fresh result is only produced while the input side is held off.
  `DGN_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

  // Status codes stay within the defined set.
  `DGN_ASSERT_NOW(a_status_code, out_valid, out_status == ST_DONE || out_status == ST_NONE || out_status == ST_EMPTY)

endmodule

bind desktop_grid_navigator_core dgn_checker u_dgn_checker (.*);
